// ===== rtl/core/cbm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the cartridge bank mapper: item types, address map, bank sizes.
// Depends on nothing; used by cbm_bank_mod, the mapper top level and its testbench.
package cbm_pkg;

    // Access kinds.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Bank geometry.
    localparam int RAM_BANKS       = 8;
    localparam int MAX_ROM_BANKS   = 128;
    localparam int MIN_ROM_BANKS   = 2;
    localparam int RAM_BANK_BYTES  = 8192;
    localparam int RAM_OFFSET_W    = $clog2(RAM_BANK_BYTES);
    localparam int RAM_DEPTH       = RAM_BANKS * RAM_BANK_BYTES;
    localparam int RAM_AW          = $clog2(RAM_DEPTH);
    localparam int ROM_OFFSET_W    = 14;
    localparam int ROM_BANK_W      = 7;
    localparam int ADDR_W          = 16;
    localparam int ROM_ADDR_W      = 21;
    localparam int COUNT_W         = 8;
    localparam int DIV_STEPS       = ROM_BANK_W;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    // Register and state reset values.
    localparam logic [COUNT_W-1:0]    BANK_COUNT_RESET = COUNT_W'(MAX_ROM_BANKS);
    localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET   = ROM_BANK_W'(1);

    // Address map limits.
    localparam logic [ADDR_W-1:0] ENABLE_LAST   = 16'h1FFF;
    localparam logic [ADDR_W-1:0] ROM_FIX_LAST  = 16'h3FFF;
    localparam logic [ADDR_W-1:0] RAM_BANK_LAST = 16'h5FFF;
    localparam logic [ADDR_W-1:0] ROM_BNK_LAST  = 16'h7FFF;
    localparam logic [ADDR_W-1:0] RAM_WIN_FIRST = 16'hA000;
    localparam logic [ADDR_W-1:0] RAM_WIN_LAST  = 16'hBFFF;

    localparam logic [3:0] ENABLE_KEY    = 4'hA;
    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_data;
    } cbm_in_t;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  rom_fetch;
        logic [ROM_ADDR_W-1:0] rom_address;
    } cbm_out_t;

endpackage

// ===== rtl/core/cbm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read port.
// Depends on nothing.
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cbm_bank_mod.sv =====
`timescale 1ns / 1ps
// Bit-serial remainder unit for ROM bank selection, one bit per cycle.
// Depends on cbm_pkg for the bank and count widths.
module cbm_bank_mod (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [cbm_pkg::ROM_BANK_W-1:0] dividend,
    input  logic [cbm_pkg::COUNT_W-1:0]    divisor,
    output logic                           done,
    output logic [cbm_pkg::ROM_BANK_W-1:0] remainder
);
    import cbm_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]  count_reg, count_next;
    logic [ROM_BANK_W-1:0] num_reg, num_next;
    logic [ROM_BANK_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0]    div_reg, div_next;
    logic [COUNT_W-1:0]    shifted;
    logic [COUNT_W-1:0]    step_rem;
    logic                  last_step;

    // The partial remainder stays below the divisor, so it fits in the bank width.
    always_comb
    begin
        shifted   = {rem_reg, num_reg[ROM_BANK_W-1]};
        step_rem  = (shifted >= div_reg) ? (shifted - div_reg) : shifted;
        last_step = busy_reg && (count_reg == DIV_CNT_W'(DIV_STEPS - 1));

        busy_next  = busy_reg;
        count_next = count_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            num_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            num_next   = {num_reg[ROM_BANK_W-2:0], 1'b0};
            rem_next   = step_rem[ROM_BANK_W-1:0];
            count_next = count_reg + DIV_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = last_step;
    assign remainder = step_rem[ROM_BANK_W-1:0];

endmodule

// ===== rtl/core/cartridge_bank_mapper_core.sv =====
`timescale 1ns / 1ps
// Top level of the cartridge bank mapper: bus access decode, bank registers,
// banked cartridge RAM. Depends on cbm_pkg, cbm_ram and cbm_bank_mod.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_data  (cbm_in_t: func, address, write_data)
//   out      output     out_valid / out_ready  out_data (cbm_out_t: read_data, rom_fetch,
//                                                        rom_address)
//   cfg      input      cfg_valid / cfg_ready  cfg_data (rom_bank_count, 8 bits)
//
// ROM reads, unmapped reads and every write except a ROM bank select finish in the
// accept cycle. A RAM read waits in ST_RAM_READ for the registered read port of
// the banked RAM. A ROM bank select sends its result at once but keeps the block busy
// for the seven steps of the bit-serial remainder unit, one bank bit per step.
// An item is taken when the block is idle and the output register is empty or
// being emptied in the same cycle, so a stalled output holds back the input.
// Reset clears the enable flag, sets ROM bank 1, RAM bank 0 and a bank count of
// 128; the RAM contents are left as they are and need no clearing pass.
module cartridge_bank_mapper_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cbm_pkg::cbm_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cbm_pkg::cbm_out_t           out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cbm_pkg::COUNT_W-1:0] cfg_data
);
    import cbm_pkg::*;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_RAM_READ = 2'd1;
    localparam logic [1:0] ST_BANK_DIV = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  ram_en_reg, ram_en_next;
    logic [ROM_BANK_W-1:0] rom_bank_reg, rom_bank_next;
    logic [7:0]            ram_bank_reg, ram_bank_next;
    logic [COUNT_W-1:0]    bank_count_reg, bank_count_next;
    logic                  out_valid_reg, out_valid_next;
    cbm_out_t              out_data_reg, out_data_next;

    logic                  in_fire;
    logic                  ram_window;
    logic                  ram_mapped;
    logic [COUNT_W-1:0]    eff_count;
    logic [ROM_BANK_W-1:0] bank_sel;

    logic                  mem_en;
    logic                  mem_we;
    logic [RAM_AW-1:0]     mem_addr;
    logic [7:0]            mem_rdata;

    logic                  div_start;
    logic                  div_done;
    logic [ROM_BANK_W-1:0] div_rem;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The RAM window is reachable only when enabled and the bank exists.
    assign ram_window = (in_data.address >= RAM_WIN_FIRST) &&
                        (in_data.address <= RAM_WIN_LAST);
    assign ram_mapped = ram_window && ram_en_reg &&
                        (ram_bank_reg < 8'(RAM_BANKS));
    assign mem_addr   = RAM_AW'({ram_bank_reg, in_data.address[RAM_OFFSET_W-1:0]});

    // The bank count is clamped into its legal range when a bank select starts.
    always_comb
    begin
        if (bank_count_reg < COUNT_W'(MIN_ROM_BANKS))
        begin
            eff_count = COUNT_W'(MIN_ROM_BANKS);
        end
        else if (bank_count_reg > COUNT_W'(MAX_ROM_BANKS))
        begin
            eff_count = COUNT_W'(MAX_ROM_BANKS);
        end
        else
        begin
            eff_count = bank_count_reg;
        end
        bank_sel = in_data.write_data[ROM_BANK_W-1:0];
        if (bank_sel == '0)
        begin
            bank_sel = ROM_BANK_W'(1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ram_en_next     = ram_en_reg;
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        bank_count_next = bank_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        div_start       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            bank_count_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Writes and most reads finish here; the result goes out at once.
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (in_data.func == FUNC_WRITE)
                    begin
                        if (in_data.address <= ENABLE_LAST)
                        begin
                            ram_en_next = (in_data.write_data[3:0] == ENABLE_KEY);
                        end
                        else if (in_data.address <= ROM_FIX_LAST)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_BANK_DIV;
                        end
                        else if (in_data.address <= RAM_BANK_LAST)
                        begin
                            ram_bank_next = in_data.write_data;
                        end
                        else if (ram_mapped)
                        begin
                            mem_en = 1'b1;
                            mem_we = 1'b1;
                        end
                    end
                    else
                    begin
                        if (in_data.address <= ROM_FIX_LAST)
                        begin
                            out_data_next.rom_fetch   = 1'b1;
                            out_data_next.rom_address = ROM_ADDR_W'(in_data.address);
                        end
                        else if (in_data.address <= ROM_BNK_LAST)
                        begin
                            out_data_next.rom_fetch   = 1'b1;
                            out_data_next.rom_address =
                                {rom_bank_reg, in_data.address[ROM_OFFSET_W-1:0]};
                        end
                        else if (ram_mapped)
                        begin
                            // The byte arrives next cycle; hold the result until then.
                            mem_en         = 1'b1;
                            out_valid_next = 1'b0;
                            state_next     = ST_RAM_READ;
                        end
                        else
                        begin
                            out_data_next.read_data = UNMAPPED_BYTE;
                        end
                    end
                end
            end
            ST_RAM_READ:
            begin
                // The output register was free when the read was taken.
                out_valid_next          = 1'b1;
                out_data_next           = '0;
                out_data_next.read_data = mem_rdata;
                state_next              = ST_IDLE;
            end
            ST_BANK_DIV:
            begin
                if (div_done)
                begin
                    rom_bank_next = div_rem;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ram_en_reg     <= 1'b0;
            rom_bank_reg   <= ROM_BANK_RESET;
            ram_bank_reg   <= '0;
            bank_count_reg <= BANK_COUNT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ram_en_reg     <= ram_en_next;
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            bank_count_reg <= bank_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    cbm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (in_data.write_data),
        .rdata (mem_rdata)
    );

    cbm_bank_mod u_bank_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (bank_sel),
        .divisor   (eff_count),
        .done      (div_done),
        .remainder (div_rem)
    );

endmodule

// ===== test/tb_cartridge_bank_mapper_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cartridge_bank_mapper_core: bus access items are driven
// with random bursts, results are checked against a shadow of the bank state.
// Depends on cbm_pkg and the mapper RTL; needs no files or arguments.
module tb_cartridge_bank_mapper_core;
    import cbm_pkg::*;

    // Shadow of the mapper: bank registers, bank count and the RAM bytes written so
    // far. Each accepted access pushes the result that it must produce, and each
    // result from the block is checked against the oldest one waiting.
    class mapper_shadow;
        logic                  ram_on;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [7:0]            ram_bank;
        logic [COUNT_W-1:0]    bank_count;
        logic [7:0]            ram_bytes [int];
        cbm_out_t              pending_results [$];
        int                    errors;

        function new();
            ram_on     = 1'b0;
            rom_bank   = ROM_BANK_RESET;
            ram_bank   = 8'd0;
            bank_count = BANK_COUNT_RESET;
            errors     = 0;
        endfunction

        // Counts outside the legal range are clamped before the modulo.
        function int modulus();
            int n;
            n = bank_count;
            if (n < MIN_ROM_BANKS)
                n = MIN_ROM_BANKS;
            if (n > MAX_ROM_BANKS)
                n = MAX_ROM_BANKS;
            return n;
        endfunction

        function bit ram_hit(logic [ADDR_W-1:0] ad);
            return ad >= RAM_WIN_FIRST && ad <= RAM_WIN_LAST && ram_on &&
                   ram_bank < RAM_BANKS;
        endfunction

        function int ram_index(logic [ADDR_W-1:0] ad);
            return int'(ram_bank) * RAM_BANK_BYTES + int'(ad[RAM_OFFSET_W-1:0]);
        endfunction

        // A read is allowed unless it would land on a RAM byte never written.
        function bit read_safe(logic [ADDR_W-1:0] ad);
            return !ram_hit(ad) || ram_bytes.exists(ram_index(ad));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void take_access(cbm_in_t a);
            cbm_out_t r;
            int       b;
            r = '0;
            if (a.func == FUNC_WRITE) begin
                if (a.address <= ENABLE_LAST) begin
                    ram_on = (a.write_data[3:0] == ENABLE_KEY);
                end
                else if (a.address <= ROM_FIX_LAST) begin
                    b = int'(a.write_data[6:0]);
                    if (b == 0)
                        b = 1;
                    rom_bank = ROM_BANK_W'(b % modulus());
                end
                else if (a.address <= RAM_BANK_LAST) begin
                    ram_bank = a.write_data;
                end
                else if (ram_hit(a.address)) begin
                    ram_bytes[ram_index(a.address)] = a.write_data;
                end
            end
            else begin
                if (a.address <= ROM_FIX_LAST) begin
                    r.rom_fetch   = 1'b1;
                    r.rom_address = ROM_ADDR_W'(a.address);
                end
                else if (a.address <= ROM_BNK_LAST) begin
                    r.rom_fetch   = 1'b1;
                    r.rom_address = {rom_bank, a.address[ROM_OFFSET_W-1:0]};
                end
                else if (ram_hit(a.address)) begin
                    r.read_data = ram_bytes[ram_index(a.address)];
                end
                else begin
                    r.read_data = UNMAPPED_BYTE;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(cbm_out_t got);
            cbm_out_t want;
            if (pending_results.size() == 0) begin
                $error("result with no access waiting: %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                errors++;
            end
            if (got.rom_fetch !== want.rom_fetch) begin
                $error("rom_fetch: expected %b, got %b", want.rom_fetch, got.rom_fetch);
                errors++;
            end
            if (got.rom_address !== want.rom_address) begin
                $error("rom_address: expected %h, got %h", want.rom_address,
                       got.rom_address);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    cbm_in_t            in_data;
    logic               out_valid;
    logic               out_ready;
    cbm_out_t           out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    mapper_shadow sb;

    cartridge_bank_mapper_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // The receiver picks a stall style for a stretch of cycles: always ready,
    // random stalls, a fixed pattern, or rare long stalls.
    initial
    begin : receiver
        int mode;
        int span;
        int hold;
        out_ready = 1'b0;
        mode = 0;
        span = 0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(50, 300);
            end
            span--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= (span % 4 != 0);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        out_ready <= 1'b0;
                    end
                    else begin
                        out_ready <= 1'b1;
                        if ($urandom_range(0, 9) == 0)
                            hold = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Presents one item at the falling edge and holds it until it is accepted.
    // The shadow is updated at the accepting edge, so the next item is chosen
    // against the state that this one leaves behind.
    task automatic send_item(input cbm_in_t a);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= a;
        do @(posedge clk); while (!in_ready);
        sb.take_access(a);
    endtask

    task automatic send_access(input logic f, input logic [ADDR_W-1:0] ad,
                               input logic [7:0] d);
        cbm_in_t a;
        a.func       = f;
        a.address    = ad;
        a.write_data = d;
        send_item(a);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stops sending until every expected result is back, then lets a bank select
    // (the slowest item) run out before anything else happens.
    task automatic drain();
        idle_sender(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_bank_count(input logic [COUNT_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.bank_count = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Most RAM window addresses come from a few offsets at each end of the bank so
    // that reads often land on bytes already written.
    function automatic logic [ADDR_W-1:0] ram_window_addr();
        logic [RAM_OFFSET_W-1:0] off;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: off = RAM_OFFSET_W'($urandom_range(0, 15));
            6, 7:             off = RAM_OFFSET_W'(13'h1FF0 + $urandom_range(0, 15));
            default:          off = RAM_OFFSET_W'($urandom);
        endcase
        return RAM_WIN_FIRST | ADDR_W'(off);
    endfunction

    // Random access, weighted toward control writes and RAM traffic. A read that
    // would hit an unwritten RAM byte is turned into a write to the same place.
    function automatic cbm_in_t make_access();
        cbm_in_t a;
        int      pick;
        a.func       = FUNC_WRITE;
        a.write_data = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            a.address = ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
            case ($urandom_range(0, 5))
                0: a.write_data = 8'h00;
                1: a.write_data = sb.bank_count;
                2: a.write_data = 8'h80;
                default: ;
            endcase
        end
        else if (pick < 15) begin
            a.address = ADDR_W'($urandom_range(0, 16'h1FFF));
            if ($urandom_range(0, 9) < 6)
                a.write_data[3:0] = ENABLE_KEY;
        end
        else if (pick < 20) begin
            a.address = ADDR_W'($urandom_range(16'h4000, 16'h5FFF));
            if ($urandom_range(0, 9) < 8)
                a.write_data = 8'($urandom_range(0, RAM_BANKS - 1));
        end
        else if (pick < 45) begin
            a.address = ram_window_addr();
        end
        else if (pick < 70) begin
            a.func    = FUNC_READ;
            a.address = ram_window_addr();
        end
        else if (pick < 85) begin
            a.func    = FUNC_READ;
            a.address = ADDR_W'($urandom_range(0, 16'h7FFF));
        end
        else begin
            a.func    = 1'($urandom);
            a.address = ADDR_W'($urandom);
        end
        if (a.func == FUNC_READ && !sb.read_safe(a.address))
            a.func = FUNC_WRITE;
        return a;
    endfunction

    // Bank counts for the phases after the first, which runs at the reset value.
    // The list covers both clamps, the legal extremes and a value with every bit set.
    localparam int N_PHASES = 11;
    localparam logic [COUNT_W-1:0] PHASE_COUNTS [N_PHASES] =
        '{8'd2, 8'd0, 8'd1, 8'd3, 8'd255, 8'd129, 8'd5, 8'd64, 8'd127, 8'd128, 8'd100};

    initial
    begin : stimulus
        int burst_left;
        int calm;
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at the reset bank count of 128.
        send_access(FUNC_READ,  16'h0000, 8'h00);  // fixed bank, lowest address
        send_access(FUNC_READ,  16'h3FFF, 8'hFF);
        send_access(FUNC_READ,  16'h4000, 8'h00);  // switchable window, bank 1
        send_access(FUNC_READ,  16'h7FFF, 8'h00);
        send_access(FUNC_READ,  16'hA000, 8'h00);  // RAM still disabled
        send_access(FUNC_WRITE, 16'hA000, 8'h11);  // dropped while disabled
        send_access(FUNC_READ,  16'h8000, 8'h00);  // unmapped
        send_access(FUNC_READ,  16'hFFFF, 8'h00);
        send_access(FUNC_WRITE, 16'h6000, 8'h01);  // clock latch range, ignored
        send_access(FUNC_WRITE, 16'hC000, 8'h22);  // unmapped write, ignored
        send_access(FUNC_WRITE, 16'h0000, 8'h0A);  // enable RAM
        send_access(FUNC_WRITE, 16'h1FFF, 8'hFA);  // key in low nibble only
        send_access(FUNC_WRITE, 16'hA000, 8'h00);
        send_access(FUNC_WRITE, 16'hBFFF, 8'hFF);
        send_access(FUNC_READ,  16'hA000, 8'h00);
        send_access(FUNC_READ,  16'hBFFF, 8'h00);
        send_access(FUNC_WRITE, 16'h2000, 8'h00);  // bank zero selects bank 1
        send_access(FUNC_WRITE, 16'h3FFF, 8'hFF);  // top bit dropped, bank 127
        send_access(FUNC_READ,  16'h7FFF, 8'h00);
        send_access(FUNC_WRITE, 16'h4000, 8'h08);  // RAM bank out of range
        send_access(FUNC_READ,  16'hA000, 8'h00);
        send_access(FUNC_WRITE, 16'h5FFF, 8'h07);  // last RAM bank
        send_access(FUNC_WRITE, 16'hA123, 8'h5A);
        send_access(FUNC_WRITE, 16'h0000, 8'h0B);  // disable again
        send_access(FUNC_READ,  16'hA123, 8'h00);

        // One phase at the reset count, then one per entry in the count list.
        // The first random phase also stops mid-way until everything is back.
        for (int ph = 0; ph <= N_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                write_bank_count(PHASE_COUNTS[ph - 1]);
                // A select equal to the count wraps the window onto bank 0 for counts from 2 to 127.
                send_access(FUNC_WRITE, 16'h2000, PHASE_COUNTS[ph - 1] & 8'h7F);
                send_access(FUNC_READ, 16'h4000, 8'h00);
            end
            calm = (ph % 4 == 3);
            burst_left = $urandom_range(1, 40);
            for (int k = 0; k < 150; k++) begin
                if (ph == 0 && k == 70)
                    drain();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    if (!calm && $urandom_range(0, 3) != 0)
                        idle_sender($urandom_range(1, 6));
                end
                burst_left--;
                send_item(make_access());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end
        else begin
            if (sb.pending() != 0)
                $error("%0d expected results never arrived", sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
